// File: src/fir_filter_circular_macros.svh
// Assertion macros for the checker file of the FIR filter.
// No dependencies; included by bare file name.
`ifndef FIR_FILTER_CIRCULAR_MACROS_SVH
`define FIR_FILTER_CIRCULAR_MACROS_SVH

// Clocked assertion, off while reset is asserted.
`define FCIRC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define FCIRC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/fcirc_pkg.sv
// Shared types, sizes and helpers for the circular-buffer FIR filter.
// No dependencies; used by every module of the block.
package fcirc_pkg;

  localparam int MAX_TAPS     = 128;
  localparam int SAMPLE_BITS  = 16;
  localparam int COEF_BITS    = 16;
  localparam int FRAC_BITS    = 15;
  localparam int TAP_CFG_BITS = 8;
  localparam int INDEX_BITS   = 7;

  localparam int ADDR_BITS = $clog2(MAX_TAPS);
  localparam int CNT_BITS  = $clog2(MAX_TAPS + 1);
  localparam int PROD_BITS = SAMPLE_BITS + COEF_BITS;
  localparam int ACC_BITS  = PROD_BITS + ADDR_BITS + 1;
  localparam int Y_BITS    = ACC_BITS - FRAC_BITS;

  typedef logic [ADDR_BITS-1:0]           addr_t;
  typedef logic [CNT_BITS-1:0]            cnt_t;
  typedef logic [TAP_CFG_BITS-1:0]        tap_cfg_t;
  typedef logic [INDEX_BITS-1:0]          index_t;
  typedef logic signed [SAMPLE_BITS-1:0]  sample_t;
  typedef logic signed [COEF_BITS-1:0]    coef_t;
  typedef logic signed [PROD_BITS-1:0]    prod_t;
  typedef logic signed [ACC_BITS-1:0]     acc_t;
  typedef logic signed [Y_BITS-1:0]       y_t;

  // Accumulator starts at half an LSB of the output so the final shift rounds.
  localparam acc_t ROUND_BIAS = acc_t'(longint'(1) << (FRAC_BITS - 1));
  localparam y_t   Y_MAX      = y_t'((longint'(1) << (SAMPLE_BITS - 1)) - 1);
  localparam y_t   Y_MIN      = y_t'(-(longint'(1) << (SAMPLE_BITS - 1)));
  localparam sample_t SAMPLE_MAX = sample_t'(Y_MAX);
  localparam sample_t SAMPLE_MIN = sample_t'(Y_MIN);
  localparam tap_cfg_t TAP_COUNT_RESET = tap_cfg_t'(1);

  typedef enum logic {
    CMD_LOAD_COEF = 1'b0,
    CMD_SAMPLE    = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e    command;
    index_t  coef_index;
    coef_t   coef_value;
    sample_t sample_in;
  } in_item_t;

  typedef struct packed {
    sample_t sample_out;
    logic    clipped;
  } out_item_t;

  // Controller to datapath.
  typedef struct packed {
    logic  coef_we;
    logic  sample_we;
    logic  clear_acc;
    logic  issue;
    addr_t coef_addr;
    logic  load_out;
  } ctl_t;

  // Datapath to controller.
  typedef struct packed {
    logic busy;
    logic out_free;
  } sts_t;

  function automatic cnt_t clamp_taps(tap_cfg_t tc);
    int unsigned t;
    t = int'(tc);
    if (t > MAX_TAPS) t = MAX_TAPS;
    return cnt_t'(t);
  endfunction

  function automatic logic coef_in_range(index_t idx);
    return int'(idx) < MAX_TAPS;
  endfunction

endpackage

// File: src/fir_filter_circular.sv
// Top level of the circular-buffer FIR filter.
// Depends on fcirc_pkg, fcirc_ctrl and fcirc_datapath.

// Direct-form FIR filter, up to MAX_TAPS Q1.15 taps, over a circular delay
// line. A tap-load transaction (command 0) writes one coefficient and returns
// nothing and does not stall the input. A sample transaction (command 1) stores
// the sample and returns one rounded, saturated output with a clip flag; the
// input is stalled while the single multiply-accumulate unit reads one
// coefficient and one delayed sample per cycle for tap_count taps (clamped to
// MAX_TAPS), then while the tap loop is left and the read and multiply
// registers drain before the sum is final.
// The result waits in an output register, so the next transaction can be taken
// while it is still stalled downstream; a sample that finishes while the
// previous result still waits holds in its drain state until that result
// leaves. Both memories clear to zero at reset through per-entry valid bits;
// no clearing pass is needed. Write tap_count only while the block is idle.
module fir_filter_circular (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  fcirc_pkg::in_item_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output fcirc_pkg::out_item_t out_data_o,
  input  logic                 cfg_we_i,
  input  fcirc_pkg::tap_cfg_t  cfg_wdata_i
);

  fcirc_pkg::ctl_t ctl;
  fcirc_pkg::sts_t sts;

  fcirc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (in_data_i.command),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .sts_i       (sts),
    .ctl_o       (ctl)
  );

  fcirc_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: src/fcirc_ctrl.sv
// Sequencer of the FIR filter: input handshake, tap counter and tap_count register.
// Depends on fcirc_pkg; drives fcirc_datapath through fcirc_pkg::ctl_t.
module fcirc_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  fcirc_pkg::cmd_e         cmd_i,
  input  logic                    cfg_we_i,
  input  fcirc_pkg::tap_cfg_t     cfg_wdata_i,
  input  fcirc_pkg::sts_t         sts_i,
  output fcirc_pkg::ctl_t         ctl_o
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_RUN   = 3'b010,
    ST_DRAIN = 3'b100
  } state_e;

  state_e              state_q, state_d;
  fcirc_pkg::cnt_t     k_q, k_d;
  fcirc_pkg::tap_cfg_t tap_count_q;
  fcirc_pkg::cnt_t     taps;
  logic                in_acc;

  assign taps       = fcirc_pkg::clamp_taps(tap_count_q);
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    ctl_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (cmd_i == fcirc_pkg::CMD_SAMPLE) begin
            ctl_o.sample_we = 1'b1;
            ctl_o.clear_acc = 1'b1;
            k_d             = '0;
            state_d         = ST_RUN;
          end else begin
            ctl_o.coef_we = 1'b1;
          end
        end
      end
      ST_RUN: begin
        if (k_q < taps) begin
          ctl_o.issue     = 1'b1;
          ctl_o.coef_addr = k_q[fcirc_pkg::ADDR_BITS-1:0];
          k_d             = k_q + fcirc_pkg::cnt_t'(1);
        end else begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // accumulator is final once the MAC pipe is empty
        if (!sts_i.busy && sts_i.out_free) begin
          ctl_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= '0;
      tap_count_q <= fcirc_pkg::TAP_COUNT_RESET;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      if (cfg_we_i) begin
        tap_count_q <= cfg_wdata_i;
      end
    end
  end

endmodule

// File: src/fcirc_datapath.sv
// Datapath of the FIR filter: coefficient and delay-line memories, MAC pipe,
// rounding, saturation and output register. Depends on fcirc_pkg.
module fcirc_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  fcirc_pkg::in_item_t  in_data_i,
  input  fcirc_pkg::ctl_t      ctl_i,
  output fcirc_pkg::sts_t      sts_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output fcirc_pkg::out_item_t out_data_o
);

  fcirc_pkg::coef_t   cf_mem [fcirc_pkg::MAX_TAPS];
  fcirc_pkg::sample_t dl_mem [fcirc_pkg::MAX_TAPS];
  logic [fcirc_pkg::MAX_TAPS-1:0] cf_vld_q;
  logic [fcirc_pkg::MAX_TAPS-1:0] dl_vld_q;

  fcirc_pkg::addr_t   wp_q, rp_q;
  fcirc_pkg::addr_t   cf_waddr;
  logic               cf_wen;

  fcirc_pkg::coef_t   cf_rd_q, cf_m;
  fcirc_pkg::sample_t dl_rd_q, dl_m;
  logic               cf_rv_q, dl_rv_q;
  logic               v1_q, v2_q;
  fcirc_pkg::prod_t   prod_q;
  fcirc_pkg::acc_t    acc_q;

  fcirc_pkg::y_t       y;
  fcirc_pkg::out_item_t res;
  fcirc_pkg::out_item_t out_q;
  logic                out_valid_q;

  assign cf_waddr = fcirc_pkg::addr_t'(in_data_i.coef_index);
  assign cf_wen   = ctl_i.coef_we && fcirc_pkg::coef_in_range(in_data_i.coef_index);

  // memory writes
  always_ff @(posedge clk_i) begin
    if (cf_wen) begin
      cf_mem[cf_waddr] <= in_data_i.coef_value;
    end
    if (ctl_i.sample_we) begin
      dl_mem[wp_q] <= in_data_i.sample_in;
    end
  end

  // memory reads, one tap per cycle
  always_ff @(posedge clk_i) begin
    if (ctl_i.issue) begin
      cf_rd_q <= cf_mem[ctl_i.coef_addr];
      dl_rd_q <= dl_mem[rp_q];
      cf_rv_q <= cf_vld_q[ctl_i.coef_addr];
      dl_rv_q <= dl_vld_q[rp_q];
    end
  end

  // never-written entries read as zero
  assign cf_m = cf_rv_q ? cf_rd_q : '0;
  assign dl_m = dl_rv_q ? dl_rd_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cf_vld_q <= '0;
      dl_vld_q <= '0;
      wp_q     <= '0;
      rp_q     <= '0;
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
    end else begin
      if (cf_wen) begin
        cf_vld_q[cf_waddr] <= 1'b1;
      end
      if (ctl_i.sample_we) begin
        dl_vld_q[wp_q] <= 1'b1;
        rp_q           <= wp_q;
        wp_q           <= (wp_q == fcirc_pkg::addr_t'(fcirc_pkg::MAX_TAPS - 1)) ?
                          '0 : wp_q + fcirc_pkg::addr_t'(1);
      end else if (ctl_i.issue) begin
        // walk back from the newest sample
        rp_q <= (rp_q == '0) ? fcirc_pkg::addr_t'(fcirc_pkg::MAX_TAPS - 1) :
                rp_q - fcirc_pkg::addr_t'(1);
      end
      v1_q <= ctl_i.issue;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= cf_m * dl_m;
    if (ctl_i.clear_acc) begin
      acc_q <= fcirc_pkg::ROUND_BIAS;
    end else if (v2_q) begin
      acc_q <= acc_q + fcirc_pkg::acc_t'(prod_q);
    end
  end

  // floor shift of the biased sum gives round-to-nearest, ties up
  assign y = acc_q[fcirc_pkg::ACC_BITS-1:fcirc_pkg::FRAC_BITS];

  always_comb begin
    res.sample_out = y[fcirc_pkg::SAMPLE_BITS-1:0];
    res.clipped    = 1'b0;
    if (y > fcirc_pkg::Y_MAX) begin
      res.sample_out = fcirc_pkg::SAMPLE_MAX;
      res.clipped    = 1'b1;
    end else if (y < fcirc_pkg::Y_MIN) begin
      res.sample_out = fcirc_pkg::SAMPLE_MIN;
      res.clipped    = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load_out) begin
      out_q <= res;
    end
  end

  assign sts_o.busy     = v1_q || v2_q;
  assign sts_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_q;

endmodule

// File: src/fcirc_checker.sv
// Port-level checks for fir_filter_circular, bound to the top level.
// Depends on fcirc_pkg and fir_filter_circular_macros.svh.
`include "fir_filter_circular_macros.svh"

module fcirc_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input fcirc_pkg::in_item_t  in_data_i,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input fcirc_pkg::out_item_t out_data_o
);

  logic smp_acc, load_acc;
  logic clip_out, at_rail, out_held;

  assign smp_acc  = in_valid_i && !in_stall_o &&
                    (in_data_i.command == fcirc_pkg::CMD_SAMPLE);
  assign load_acc = in_valid_i && !in_stall_o &&
                    (in_data_i.command == fcirc_pkg::CMD_LOAD_COEF);
  assign clip_out = out_valid_o && out_data_o.clipped;
  assign at_rail  = (out_data_o.sample_out == fcirc_pkg::SAMPLE_MAX) ||
                    (out_data_o.sample_out == fcirc_pkg::SAMPLE_MIN);
  assign out_held = out_valid_o && out_stall_i;

  // a sample transaction keeps the block busy for the MAC run
  `FCIRC_ASSERT(a_sample_busy, clk_i, rst_ni, smp_acc |=> in_stall_o, "no stall after sample")

  // a coefficient load does not stall the input
  `FCIRC_ASSERT(a_load_fast, clk_i, rst_ni, load_acc |=> !in_stall_o, "stall after coef load")

  // clip flag only with a rail value
  `FCIRC_ASSERT(a_clip_rail, clk_i, rst_ni, clip_out |-> at_rail, "clipped output not at a rail")

  // stalled result holds
  `FCIRC_ASSERT(a_out_hold, clk_i, rst_ni,
                out_held |=> $stable({out_valid_o, out_data_o}), "stalled output changed")

  // input side is ready after a reset edge
  `FCIRC_ASSERT_ALWAYS(a_rst_ready, clk_i, !rst_ni |=> !in_stall_o, "stalled after reset")

endmodule

bind fir_filter_circular fcirc_checker u_fcirc_checker (.*);

// File: tb/testbench.sv
// Self-checking testbench for fir_filter_circular: drives tap-load and sample
// transactions, predicts every filtered output and compares it field by field.
// Depends on fcirc_pkg and the fir_filter_circular RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STUCK_LIMIT   = 3000;
  localparam int SETTLE_CYCLES = fcirc_pkg::MAX_TAPS + 16;
  localparam int LONG_HOLD     = 400;
  localparam int HOLD_AFTER    = 200;
  localparam int PHASES        = 20;

  // Tracks the filter state and holds the outputs still owed by the block.
  class fir_scoreboard;
    fcirc_pkg::sample_t   history [fcirc_pkg::MAX_TAPS];
    fcirc_pkg::coef_t     coefs   [fcirc_pkg::MAX_TAPS];
    int                   wr_pos;
    fcirc_pkg::tap_cfg_t  n_taps;
    fcirc_pkg::out_item_t filtered_q [$];
    int                   errors;

    function new();
      foreach (history[i]) begin
        history[i] = '0;
        coefs[i]   = '0;
      end
      wr_pos = 0;
      n_taps = fcirc_pkg::TAP_COUNT_RESET;
      errors = 0;
    endfunction

    function void set_taps(fcirc_pkg::tap_cfg_t v);
      n_taps = v;
    endfunction

    function void take_item(fcirc_pkg::in_item_t it);
      longint               acc;
      longint               y;
      int                   n;
      int                   slot;
      fcirc_pkg::out_item_t r;
      if (it.command == fcirc_pkg::CMD_LOAD_COEF) begin
        coefs[int'(it.coef_index)] = it.coef_value;
        return;
      end
      history[wr_pos] = it.sample_in;
      n = (int'(n_taps) > fcirc_pkg::MAX_TAPS) ? fcirc_pkg::MAX_TAPS : int'(n_taps);
      acc = 0;
      for (int k = 0; k < n; k++) begin
        slot = (wr_pos + fcirc_pkg::MAX_TAPS - k) % fcirc_pkg::MAX_TAPS;
        acc += longint'(coefs[k]) * longint'(history[slot]);
      end
      // round half up, then floor shift
      y = (acc + (longint'(1) << (fcirc_pkg::FRAC_BITS - 1))) >>> fcirc_pkg::FRAC_BITS;
      r.clipped = 1'b0;
      if (y > longint'(fcirc_pkg::SAMPLE_MAX)) begin
        y = longint'(fcirc_pkg::SAMPLE_MAX);
        r.clipped = 1'b1;
      end else if (y < longint'(fcirc_pkg::SAMPLE_MIN)) begin
        y = longint'(fcirc_pkg::SAMPLE_MIN);
        r.clipped = 1'b1;
      end
      r.sample_out = fcirc_pkg::sample_t'(y);
      wr_pos = (wr_pos + 1) % fcirc_pkg::MAX_TAPS;
      filtered_q.push_back(r);
    endfunction

    function void check_output(fcirc_pkg::out_item_t got);
      fcirc_pkg::out_item_t want;
      if (filtered_q.size() == 0) begin
        $display("%0t: unexpected output, expected none, actual sample_out %0d clipped %0b",
                 $time, got.sample_out, got.clipped);
        errors++;
        return;
      end
      want = filtered_q.pop_front();
      if (got.sample_out !== want.sample_out) begin
        $display("%0t: sample_out mismatch, expected %0d, actual %0d",
                 $time, want.sample_out, got.sample_out);
        errors++;
      end
      if (got.clipped !== want.clipped) begin
        $display("%0t: clipped mismatch, expected %0b, actual %0b",
                 $time, want.clipped, got.clipped);
        errors++;
      end
    endfunction
  endclass

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  fcirc_pkg::in_item_t  in_data   = '0;
  logic                 in_stall;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  fcirc_pkg::out_item_t out_data;
  logic                 cfg_we    = 1'b0;
  fcirc_pkg::tap_cfg_t  cfg_wdata = '0;

  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;

  fir_scoreboard sb = new();

  fir_filter_circular u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic fcirc_pkg::in_item_t mk_load(int idx, int val);
    fcirc_pkg::in_item_t it;
    it.command    = fcirc_pkg::CMD_LOAD_COEF;
    it.coef_index = fcirc_pkg::index_t'(idx);
    it.coef_value = fcirc_pkg::coef_t'(val);
    it.sample_in  = fcirc_pkg::sample_t'($urandom);
    return it;
  endfunction

  function automatic fcirc_pkg::in_item_t mk_sample(int val);
    fcirc_pkg::in_item_t it;
    it.command    = fcirc_pkg::CMD_SAMPLE;
    it.coef_index = fcirc_pkg::index_t'($urandom);
    it.coef_value = fcirc_pkg::coef_t'($urandom);
    it.sample_in  = fcirc_pkg::sample_t'(val);
    return it;
  endfunction

  // Full-scale values show up often enough to drive the sum into saturation.
  function automatic int pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 32767;
    if (r == 1) return -32768;
    return int'($urandom_range(0, 65535));
  endfunction

  function automatic fcirc_pkg::in_item_t rand_item(fcirc_pkg::tap_cfg_t taps);
    int lim;
    int idx;
    lim = (taps == 0 || int'(taps) > fcirc_pkg::MAX_TAPS) ? fcirc_pkg::MAX_TAPS
                                                          : int'(taps);
    if ($urandom_range(0, 9) < 3) begin
      // mostly load taps that are actually in use
      idx = $urandom_range(0, 1) ? $urandom_range(0, lim - 1)
                                 : $urandom_range(0, fcirc_pkg::MAX_TAPS - 1);
      return mk_load(idx, pick_value());
    end
    return mk_sample(pick_value());
  endfunction

  task automatic send_item(input fcirc_pkg::in_item_t it);
    int gap;
    gap = tx_idle ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.take_item(it);
  endtask

  // Wait for every owed output, then give in-flight work time to finish.
  task automatic drain_and_settle();
    in_valid <= 1'b0;
    while (sb.filtered_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_taps(input fcirc_pkg::tap_cfg_t v);
    drain_and_settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_taps(v);
  endtask

  // Output side: random stalls, plus one long hold to back the block up.
  initial begin
    int gap;
    int n_got;
    bit held;
    n_got = 0;
    held  = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      gap = rx_idle ? $urandom_range(0, 6) : 0;
      if (!held && n_got == HOLD_AFTER) begin
        held = 1'b1;
        gap  = LONG_HOLD;
      end
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      sb.check_output(out_data);
      n_got++;
    end
  end

  initial begin
    int stuck;
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck = 0;
      else stuck++;
    end
    $display("testbench: errors");
    $finish;
  end

  initial begin
    fcirc_pkg::tap_cfg_t taps;
    int                  n_items;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single tap from reset; coefficients start at zero
    send_item(mk_sample(32767));
    send_item(mk_load(0, 32767));
    send_item(mk_load(fcirc_pkg::MAX_TAPS - 1, 32767));
    send_item(mk_sample(32767));
    send_item(mk_sample(-32768));
    send_item(mk_load(0, -32768));
    send_item(mk_sample(-32768));   // -1.0 * -1.0 saturates high
    send_item(mk_load(0, 1));
    send_item(mk_sample(16384));    // exact half rounds up
    send_item(mk_sample(-16384));   // negative half rounds toward zero
    send_item(mk_sample(-16385));

    write_taps(fcirc_pkg::tap_cfg_t'(2));
    send_item(mk_load(0, -32768));
    send_item(mk_load(1, -32768));
    send_item(mk_sample(32767));
    send_item(mk_sample(32767));    // saturates low

    write_taps(fcirc_pkg::tap_cfg_t'(0));  // no taps: output zero, sample still stored
    send_item(mk_sample(12345));
    send_item(mk_sample(-32768));

    write_taps(fcirc_pkg::tap_cfg_t'(fcirc_pkg::MAX_TAPS));
    send_item(mk_sample(-32768));
    send_item(mk_sample(32767));

    write_taps(fcirc_pkg::tap_cfg_t'(255));  // clamps to the full line
    send_item(mk_sample(32767));

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          taps = fcirc_pkg::tap_cfg_t'(1);
        end
        1: begin
          taps = fcirc_pkg::tap_cfg_t'(fcirc_pkg::MAX_TAPS);
        end
        2: begin
          taps = fcirc_pkg::tap_cfg_t'(0);
        end
        3: begin
          taps = fcirc_pkg::tap_cfg_t'(fcirc_pkg::MAX_TAPS + 1);
        end
        4: begin
          taps = fcirc_pkg::tap_cfg_t'(255);
        end
        default: begin
          taps = (p % 5 == 0) ? fcirc_pkg::tap_cfg_t'($urandom_range(17, 255))
                              : fcirc_pkg::tap_cfg_t'($urandom_range(1, 16));
        end
      endcase
      write_taps(taps);
      tx_idle = (p == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
      rx_idle = (p == 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
      n_items = (int'(taps) > 32) ? 40 : 130;
      repeat (n_items) send_item(rand_item(taps));
    end

    drain_and_settle();
    if (sb.errors == 0 && sb.filtered_q.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

// File: fir_filter_circular.f
+incdir+src
src/fcirc_pkg.sv
src/fcirc_ctrl.sv
src/fcirc_datapath.sv
src/fir_filter_circular.sv
src/fcirc_checker.sv
tb/testbench.sv
